// File: sv/htx_pkg.sv
// Shared types, character codes, match patterns and helpers for the markup text extractor.
package htx_pkg;

    // Default depth of the lookahead window and the span that patterns cover
    localparam int LOOKAHEAD_DEF = 6;
    localparam int PAT_BYTES     = 6;
    localparam int HEAD_W        = 8 * PAT_BYTES;

    // Character codes
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_APOS = 8'h27;

    // Patterns, lower case, first character in the top byte
    localparam logic [HEAD_W-1:0] PAT_BODY    = {"<body", 8'h00};
    localparam logic [HEAD_W-1:0] PAT_BODY_CL = {"</body"};
    localparam logic [HEAD_W-1:0] PAT_P       = {"<p", 32'h0};
    localparam logic [HEAD_W-1:0] PAT_DIV     = {"<div", 16'h0};
    localparam logic [HEAD_W-1:0] PAT_BR      = {"<br", 24'h0};
    localparam logic [HEAD_W-1:0] PAT_H       = {"<h", 32'h0};
    localparam logic [HEAD_W-1:0] PAT_LI      = {"<li>", 16'h0};
    localparam logic [HEAD_W-1:0] PAT_TR      = {"<tr>", 16'h0};
    localparam logic [HEAD_W-1:0] PAT_NBSP    = {"&nbsp;"};
    localparam logic [HEAD_W-1:0] PAT_LT      = {"&lt;", 16'h0};
    localparam logic [HEAD_W-1:0] PAT_GT      = {"&gt;", 16'h0};
    localparam logic [HEAD_W-1:0] PAT_AMP     = {"&amp;", 8'h00};
    localparam logic [HEAD_W-1:0] PAT_QUOT    = {"&quot;"};
    localparam logic [HEAD_W-1:0] PAT_APOS    = {"&apos;"};

    // Input and result payloads
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // Scanner state carried from byte to byte
    typedef struct packed {
        logic       in_tag;
        logic       in_body;
        logic [2:0] skip;
    } scan_state_t;

    // Outcome of scanning the window head
    typedef struct packed {
        logic        emit;
        logic [7:0]  char_out;
        scan_state_t state;
    } scan_result_t;

    // Fold ASCII upper case letters to lower case
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // Match the first len bytes of the head against a pattern; invalid bytes mismatch
    function automatic logic pat_hit(
        input logic [HEAD_W-1:0]    head,
        input logic [PAT_BYTES-1:0] vld,
        input logic [HEAD_W-1:0]    pat,
        input logic [2:0]           len
    );
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < PAT_BYTES; i++) begin
            if (3'(i) < len) begin
                if (!vld[i] ||
                    fold(head[HEAD_W-1-8*i -: 8]) != pat[HEAD_W-1-8*i -: 8]) begin
                    hit = 1'b0;
                end
            end
        end
        return hit;
    endfunction

endpackage

// File: sv/html_text_extractor.sv
// A byte is scanned once the transfer that puts LOOKAHEAD-1 bytes behind it is registered;
// its text character then passes the hold stage (h_byte_reg) and output register to m_data.
// Throughput: one byte per cycle, one head scan per cycle through the window, while the output does not stall.
// End of stream: the window drains one byte per cycle unless the output stalls; input is held
// (s_ready low) until every byte left in the window has been scanned.
// Reset (aresetn low, synchronous) empties the window and pipeline and clears body_default.
module html_text_extractor #(
    parameter int LOOKAHEAD = htx_pkg::LOOKAHEAD_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  htx_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output htx_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_data
);
    import htx_pkg::*;

    localparam int WIN_D = LOOKAHEAD + 1;
    localparam int CNT_W = $clog2(WIN_D + 1);

    logic [7:0]       win_reg [WIN_D];
    logic [7:0]       win_next [WIN_D];
    logic [CNT_W-1:0] count_reg, count_next, wr_pos;
    logic             flush_reg, flush_next;
    logic             start_reg, start_next;
    logic             body_default_reg;
    scan_state_t      st_reg, st_next;
    logic             h_valid_reg, h_valid_next;
    logic             h_done_reg, h_done_next;
    logic [7:0]       h_byte_reg, h_byte_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic [HEAD_W-1:0]    head;
    logic [PAT_BYTES-1:0] vld;
    scan_result_t         scan_res;
    logic                 o_free, step_avail, fl_step, fin, go, accept;

    // Present the window head to the scanner
    always_comb begin
        for (int i = 0; i < PAT_BYTES; i++) begin
            head[HEAD_W-1-8*i -: 8] = win_reg[i];
            vld[i]                  = count_reg > CNT_W'(i);
        end
    end

    htx_scan u_scan (
        .head     (head),
        .vld      (vld),
        .state_in (st_reg),
        .res      (scan_res)
    );

    // Step and transfer control
    assign o_free     = !m_valid_reg || m_ready;
    assign step_avail = (count_reg >= CNT_W'(LOOKAHEAD)) || (flush_reg && count_reg != '0);
    assign fl_step    = flush_reg && count_reg <= CNT_W'(LOOKAHEAD);
    assign fin        = flush_reg && count_reg == CNT_W'(1);
    assign s_ready    = !flush_reg && count_reg < CNT_W'(WIN_D);
    assign accept     = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    always_comb begin
        if (!h_valid_reg) begin
            go = step_avail;
        end else if (h_done_reg) begin
            go = step_avail && o_free;
        end else begin
            go = step_avail && (o_free || !scan_res.emit);
        end
    end

    // Hold stage and output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        h_valid_next = h_valid_reg;
        h_done_next  = h_done_reg;
        h_byte_next  = h_byte_reg;
        if (h_valid_reg && h_done_reg && o_free) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = h_byte_reg;
            m_data_next.run_last = 1'b1;
            h_valid_next         = 1'b0;
        end else if (h_valid_reg && !h_done_reg && go && scan_res.emit) begin
            m_valid_next         = 1'b1;
            m_data_next.out_byte = h_byte_reg;
            m_data_next.run_last = 1'b0;
            h_valid_next         = 1'b0;
        end
        if (go) begin
            if (scan_res.emit) begin
                h_valid_next = 1'b1;
                h_byte_next  = scan_res.char_out;
                h_done_next  = !fl_step || fin;
            end else if (h_valid_reg && !h_done_reg) begin
                h_done_next = fin;
            end
        end
    end

    // Window shift and load, scanner state, stream control
    always_comb begin
        st_next    = st_reg;
        flush_next = flush_reg;
        start_next = start_reg;
        for (int i = 0; i < WIN_D; i++) begin
            win_next[i] = win_reg[i];
        end
        if (go) begin
            st_next = scan_res.state;
            for (int i = 0; i < WIN_D - 1; i++) begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_D-1] = 8'h00;
            if (fin) begin
                st_next.in_tag = 1'b0;
                st_next.skip   = 3'd0;
                flush_next     = 1'b0;
                start_next     = 1'b1;
            end
        end
        wr_pos = count_reg - CNT_W'(go);
        if (accept) begin
            for (int i = 0; i < WIN_D; i++) begin
                if (CNT_W'(i) == wr_pos) begin
                    win_next[i] = s_data.in_byte;
                end
            end
            if (start_reg) begin
                st_next.in_body = body_default_reg;
                start_next      = 1'b0;
            end
            if (s_data.end_of_stream) begin
                flush_next = 1'b1;
            end
        end
        count_next = wr_pos + CNT_W'(accept);
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg        <= '0;
            flush_reg        <= 1'b0;
            start_reg        <= 1'b1;
            body_default_reg <= 1'b0;
            st_reg           <= '0;
            h_valid_reg      <= 1'b0;
            h_done_reg       <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            count_reg   <= count_next;
            flush_reg   <= flush_next;
            start_reg   <= start_next;
            st_reg      <= st_next;
            h_valid_reg <= h_valid_next;
            h_done_reg  <= h_done_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                body_default_reg <= cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        for (int i = 0; i < WIN_D; i++) begin
            win_reg[i] <= win_next[i];
        end
        h_byte_reg <= h_byte_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: sv/htx_scan.sv
// Window head scanner: tag tracking, body mode, block breaks and entity decode.
module htx_scan (
    input  logic [htx_pkg::HEAD_W-1:0]    head,
    input  logic [htx_pkg::PAT_BYTES-1:0] vld,
    input  htx_pkg::scan_state_t          state_in,
    output htx_pkg::scan_result_t         res
);
    import htx_pkg::*;

    logic [7:0] c;
    logic       body_next;
    logic       brk_hit;

    assign c = head[HEAD_W-1 -: 8];

    // Any block tag that starts a new line
    assign brk_hit = pat_hit(head, vld, PAT_P,   3'd2) || pat_hit(head, vld, PAT_DIV, 3'd4) ||
                     pat_hit(head, vld, PAT_BR,  3'd3) || pat_hit(head, vld, PAT_H,   3'd2) ||
                     pat_hit(head, vld, PAT_LI,  3'd4) || pat_hit(head, vld, PAT_TR,  3'd4);

    // Body mode after a tag opener
    always_comb begin
        body_next = state_in.in_body;
        if (pat_hit(head, vld, PAT_BODY, 3'd5)) begin
            body_next = 1'b1;
        end
        if (pat_hit(head, vld, PAT_BODY_CL, 3'd6)) begin
            body_next = 1'b0;
        end
    end

    // Classify the head byte
    always_comb begin
        res          = '0;
        res.state    = state_in;
        res.char_out = c;
        priority if (state_in.skip != 3'd0) begin
            res.state.skip = state_in.skip - 3'd1;
        end else if (c == CH_LT) begin
            res.state.in_tag  = 1'b1;
            res.state.in_body = body_next;
            res.emit          = body_next && brk_hit;
            res.char_out      = CH_CR;
        end else if (c == CH_GT) begin
            res.state.in_tag = 1'b0;
        end else if (state_in.in_tag || !state_in.in_body) begin
            res.emit = 1'b0;
        end else if (c == CH_AMP) begin
            res.emit = 1'b1;
            priority if (pat_hit(head, vld, PAT_NBSP, 3'd6)) begin
                res.char_out   = CH_SP;
                res.state.skip = 3'd5;
            end else if (pat_hit(head, vld, PAT_LT, 3'd4)) begin
                res.char_out   = CH_LT;
                res.state.skip = 3'd3;
            end else if (pat_hit(head, vld, PAT_GT, 3'd4)) begin
                res.char_out   = CH_GT;
                res.state.skip = 3'd3;
            end else if (pat_hit(head, vld, PAT_AMP, 3'd5)) begin
                res.char_out   = CH_AMP;
                res.state.skip = 3'd4;
            end else if (pat_hit(head, vld, PAT_QUOT, 3'd6)) begin
                res.char_out   = CH_QUOT;
                res.state.skip = 3'd5;
            end else if (pat_hit(head, vld, PAT_APOS, 3'd6)) begin
                res.char_out   = CH_APOS;
                res.state.skip = 3'd5;
            end else begin
                res.char_out = CH_AMP;
            end
        end else if (c == CH_CR || c == CH_LF) begin
            res.emit     = 1'b1;
            res.char_out = CH_SP;
        end else begin
            res.emit = 1'b1;
        end
    end

endmodule

// File: dv/tb.sv
// Self-checking testbench for the markup text extractor: random byte streams, predicted text.
`timescale 1ns / 1ps

module tb;
    import htx_pkg::*;

    localparam int LA           = LOOKAHEAD_DEF;
    localparam int DRAIN_CYCLES = 2 * LA + 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_data    = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    // Stimulus feed and expected text
    in_item_t  byte_feed_q[$];
    out_item_t text_exp_q[$];
    int        n_queued      = 0;
    int        n_accepted    = 0;
    int        mismatches    = 0;
    int        cycles        = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    out_item_t want_item;

    // Predictor state
    logic [7:0] la_win [LA] = '{default: 8'h00};
    int         la_fill       = 0;
    int         skip_left     = 0;
    bit         in_markup     = 1'b0;
    bit         in_text_body  = 1'b0;
    bit         fresh_stream  = 1'b1;
    bit         body_at_start = 1'b0;

    html_text_extractor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Generate the clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Compare the window head with a pattern; bytes past the fill never match
    function automatic bit win_has(input string pat, input int n);
        for (int i = 0; i < pat.len(); i++) begin
            if (i >= n || i >= LA) begin
                return 1'b0;
            end
            if (to_lower(la_win[i]) != to_lower(pat[i])) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Scan the head byte; return the text character or -1 for none
    function automatic int scan_head(input int n);
        logic [7:0] c;
        c = la_win[0];
        if (skip_left > 0) begin
            skip_left--;
            return -1;
        end
        if (c == CH_LT) begin
            in_markup = 1'b1;
            if (win_has("<body", n)) begin
                in_text_body = 1'b1;
            end
            if (win_has("</body", n)) begin
                in_text_body = 1'b0;
            end
            if (in_text_body && (win_has("<p", n) || win_has("<div", n) ||
                                 win_has("<br", n) || win_has("<h", n) ||
                                 win_has("<li>", n) || win_has("<tr>", n))) begin
                return int'(CH_CR);
            end
            return -1;
        end
        if (c == CH_GT) begin
            in_markup = 1'b0;
            return -1;
        end
        if (in_markup || !in_text_body) begin
            return -1;
        end
        if (c == CH_AMP) begin
            if (win_has("&nbsp;", n)) begin
                skip_left = 5;
                return int'(CH_SP);
            end
            if (win_has("&lt;", n)) begin
                skip_left = 3;
                return int'(CH_LT);
            end
            if (win_has("&gt;", n)) begin
                skip_left = 3;
                return int'(CH_GT);
            end
            if (win_has("&amp;", n)) begin
                skip_left = 4;
                return int'(CH_AMP);
            end
            if (win_has("&quot;", n)) begin
                skip_left = 5;
                return int'(CH_QUOT);
            end
            if (win_has("&apos;", n)) begin
                skip_left = 5;
                return int'(CH_APOS);
            end
            return int'(CH_AMP);
        end
        if (c == CH_CR || c == CH_LF) begin
            return int'(CH_SP);
        end
        return int'(c);
    endfunction

    function automatic void shift_win();
        for (int i = 0; i + 1 < LA; i++) begin
            la_win[i] = la_win[i + 1];
        end
        la_win[LA - 1] = 8'h00;
        if (la_fill > 0) begin
            la_fill--;
        end
    endfunction

    // Advance the predictor by one accepted byte and queue the text it yields
    task automatic predict_text(input in_item_t it);
        logic [7:0] chars[$];
        out_item_t  item;
        int         r;
        if (fresh_stream) begin
            in_text_body = body_at_start;
            fresh_stream = 1'b0;
        end
        if (la_fill >= LA) begin
            la_fill = LA - 1;
        end
        la_win[la_fill] = it.in_byte;
        la_fill++;
        if (la_fill >= LA) begin
            r = scan_head(la_fill);
            shift_win();
            if (r >= 0) begin
                chars.push_back(r[7:0]);
            end
        end
        // Flush the window at end of stream
        if (it.end_of_stream) begin
            while (la_fill > 0) begin
                r = scan_head(la_fill);
                shift_win();
                if (r >= 0 && chars.size() < LA) begin
                    chars.push_back(r[7:0]);
                end
            end
            la_win       = '{default: 8'h00};
            la_fill      = 0;
            in_markup    = 1'b0;
            skip_left    = 0;
            fresh_stream = 1'b1;
        end
        foreach (chars[i]) begin
            item.out_byte = chars[i];
            item.run_last = (i == chars.size() - 1);
            text_exp_q.push_back(item);
        end
    endtask

    // Driver: present the next pending byte, hold it until the transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_text(s_data);
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (byte_feed_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= byte_feed_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transfer against the oldest expected character
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (text_exp_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result out_byte=%02h run_last=%0b",
                             $time, m_data.out_byte, m_data.run_last);
                end else begin
                    want_item = text_exp_q.pop_front();
                    if (m_data.out_byte !== want_item.out_byte ||
                        m_data.run_last !== want_item.run_last) begin
                        mismatches++;
                        $display("%0t: exp byte=%02h last=%0b, got byte=%02h last=%0b",
                                 $time, want_item.out_byte, want_item.run_last,
                                 m_data.out_byte, m_data.run_last);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic feed_byte(input logic [7:0] b, input bit eos);
        in_item_t it;
        it.in_byte       = b;
        it.end_of_stream = eos;
        byte_feed_q.push_back(it);
        n_queued++;
    endtask

    // Queue a string, optionally with mixed case and random stream ends
    task automatic feed_str(input string s, input bit mix_case, input bit allow_end);
        logic [7:0] b;
        for (int i = 0; i < s.len(); i++) begin
            b = s[i];
            if (mix_case && b >= "a" && b <= "z" && $urandom_range(0, 1) == 1) begin
                b = b - 8'h20;
            end
            feed_byte(b, allow_end && ($urandom_range(0, 79) == 0));
        end
    endtask

    // Queue one markup token: tags, entities, line breaks, text or noise
    task automatic feed_token();
        int k;
        k = $urandom_range(0, 31);
        case (k)
            0, 1:    feed_str("<body>", 1'b1, 1'b1);
            2:       feed_str("</body>", 1'b1, 1'b1);
            3:       feed_str("<p>", 1'b1, 1'b1);
            4:       feed_str("<div id=a>", 1'b1, 1'b1);
            5:       feed_str("<br/>", 1'b1, 1'b1);
            6:       feed_str("<h2>", 1'b1, 1'b1);
            7:       feed_str("<li>", 1'b1, 1'b1);
            8:       feed_str("<tr>", 1'b1, 1'b1);
            9:       feed_str("<li x>", 1'b1, 1'b1);
            10:      feed_str("<span>", 1'b1, 1'b1);
            11:      feed_str("<pre>", 1'b1, 1'b1);
            12:      feed_str("&nbsp;", 1'b1, 1'b1);
            13:      feed_str("&lt;", 1'b1, 1'b1);
            14:      feed_str("&gt;", 1'b1, 1'b1);
            15:      feed_str("&amp;", 1'b1, 1'b1);
            16:      feed_str("&quot;", 1'b1, 1'b1);
            17:      feed_str("&apos;", 1'b1, 1'b1);
            18:      feed_str("&nbs", 1'b1, 1'b1);
            19:      feed_str("&zz;", 1'b1, 1'b1);
            20:      feed_byte(CH_CR, $urandom_range(0, 79) == 0);
            21:      feed_byte(CH_LF, $urandom_range(0, 79) == 0);
            22:      feed_byte(CH_GT, $urandom_range(0, 79) == 0);
            23:      feed_byte(CH_LT, $urandom_range(0, 79) == 0);
            24, 25:  feed_byte(8'($urandom_range(0, 255)), $urandom_range(0, 79) == 0);
            default: begin
                repeat ($urandom_range(1, 4)) begin
                    feed_byte(8'($urandom_range(32, 126)), $urandom_range(0, 79) == 0);
                end
            end
        endcase
    endtask

    // Queue a run of random tokens, closed by an end of stream
    task automatic feed_random(input int count);
        int start;
        start = n_queued;
        while (n_queued - start < count) begin
            feed_token();
        end
        feed_byte(8'($urandom_range(32, 126)), 1'b1);
    endtask

    // Wait until every byte is taken and every result has arrived, then let the flush settle
    task automatic drain();
        while (n_accepted != n_queued || text_exp_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_body_default(input logic val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        body_at_start = val;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: block tag, entities, line breaks, unknown entity, byte extremes,
        // and a tag cut short by the end of stream
        send_idle_pct = 15;
        recv_idle_pct = 79;
        set_body_default(1'b1);
        feed_str("<Div>&Lt;&amp;\n", 1'b0, 1'b0);
        feed_byte(CH_CR, 1'b0);
        feed_str("&x", 1'b0, 1'b0);
        feed_byte(8'h00, 1'b0);
        feed_byte(8'hFF, 1'b0);
        feed_str("<b", 1'b0, 1'b0);
        feed_byte("R", 1'b1);
        drain();

        // Random streams, sender idles lightly and receiver stalls heavily
        set_body_default(1'b0);
        feed_random(115);
        drain();

        // Swap the idling of the two sides
        send_idle_pct = 79;
        recv_idle_pct = 15;
        set_body_default(1'b1);
        feed_random(115);
        drain();

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_body_default(1'b0);
        feed_random(120);
        drain();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
